// ----- rtl/imvpe_pkg.sv -----
// ----------------------------------------------------------------------------
// imvpe_pkg
// Constants, register indexes and saturation helpers for the pose estimator.
// ----------------------------------------------------------------------------
package imvpe_pkg;

  localparam int unsigned MAX_TRACKS_DEF = 64;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MPP         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FPS         = 3'd4;

  localparam logic [15:0] TICK_PERIOD_RST = 16'd2163;
  localparam logic [15:0] POS_GAIN_RST    = 16'd19661;
  localparam logic [15:0] VEL_GAIN_RST    = 16'd13107;
  localparam logic [15:0] MPP_RST         = 16'd655;
  localparam logic [9:0]  FPS_RST         = 10'd30;

  localparam logic [1:0] CMD_IMU        = 2'd0;
  localparam logic [1:0] CMD_TRACK      = 2'd1;
  localparam logic [1:0] CMD_TRACK_LAST = 2'd2;

  localparam int unsigned PROD_W = 66;
  localparam int unsigned DVD_W  = 56;

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [41:0] x);
    logic signed [39:0] r;
    if (x > 42'sd549755813887) begin
      r = {1'b0, {39{1'b1}}};
    end else if (x < -42'sd549755813888) begin
      r = {1'b1, {39{1'b0}}};
    end else begin
      r = x[39:0];
    end
    return r;
  endfunction

  function automatic logic signed [47:0] clamp48(input logic signed [56:0] x);
    logic signed [47:0] r;
    if (x > 57'sd140737488355327) begin
      r = {1'b0, {47{1'b1}}};
    end else if (x < -57'sd140737488355328) begin
      r = {1'b1, {47{1'b0}}};
    end else begin
      r = x[47:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/imu_visual_pose_estimator_core.sv -----
// ----------------------------------------------------------------------------
// imu_visual_pose_estimator_core
// IMU dead reckoning with visual track blending on one shared multiplier.
// An IMU word runs twelve multiply/accumulate steps on the multiplier.
// A track word is summed while idle. A last track word also runs four
// 56-step serial divisions plus the blend multiplies.
// The block takes one word at a time. Reset clears pose and sums and loads the
// register defaults.
// ----------------------------------------------------------------------------
module imu_visual_pose_estimator_core
  import imvpe_pkg::*;
#(
  parameter int unsigned MAX_TRACKS = MAX_TRACKS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           cmd_i,
  input  logic signed [31:0]   ax_or_left_i,
  input  logic signed [31:0]   ay_or_top_i,
  input  logic signed [31:0]   az_or_width_i,
  input  logic signed [31:0]   gx_or_height_i,
  input  logic signed [31:0]   gy_or_track_vx_i,
  input  logic signed [31:0]   gz_or_track_vy_i,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   pos_x_o,
  output logic signed [31:0]   pos_y_o,
  output logic signed [31:0]   pos_z_o,
  output logic signed [31:0]   vel_x_o,
  output logic signed [31:0]   vel_y_o,
  output logic signed [31:0]   vel_z_o,
  output logic signed [31:0]   roll_angle_o,
  output logic signed [31:0]   pitch_angle_o,
  output logic signed [31:0]   yaw_angle_o
);

  localparam int unsigned CNT_W = $clog2(MAX_TRACKS + 1);
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

  typedef enum logic [3:0] {
    S_IDLE, S_IMUL, S_IACC, S_FMUL, S_FLOAD, S_FDIV, S_FSGN,
    S_FVMUL, S_FVTGT, S_BMUL, S_BACC, S_OUT
  } state_e;

  state_e state_q;

  logic [15:0] tick_q, pgain_q, vgain_q, mpp_q;
  logic [9:0]  fps_q;

  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic signed [31:0] ang_q [3];
  logic signed [31:0] acc_in_q [3];
  logic signed [31:0] rate_in_q [3];

  logic signed [39:0] csx_q, csy_q, tvx_q, tvy_q;
  logic [CNT_W-1:0]   cnt_q;

  logic [1:0] ax_q, st_q;
  logic [2:0] j_q;
  logic signed [31:0] adt_q, half_q, tgt_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [DVD_W-1:0]   dvd_q;
  logic [CNT_W:0]     rem_q;
  logic               neg_q;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic signed [56:0] q_q;

  logic signed [31:0] out_q [9];
  logic               out_valid_q;

  // operand selection for the shared multiplier
  logic signed [47:0] opa;
  logic signed [17:0] opb;
  logic signed [PROD_W-1:0] prod_d;
  logic [1:0] pidx, vidx;
  logic signed [31:0] bold;
  logic signed [39:0] sum_sel;
  logic [15:0] gsel;

  always_comb begin
    pidx = ax_q;
    vidx = ax_q;
    if (state_q == S_BMUL || state_q == S_BACC) begin
      pidx = (j_q == 3'd4) ? 2'd2 : {1'b0, j_q[0]};
      vidx = {1'b0, j_q[0]};
    end
    bold = (j_q == 3'd2 || j_q == 3'd3) ? vel_q[vidx] : pos_q[pidx];
    gsel = (j_q == 3'd2 || j_q == 3'd3) ? vgain_q : pgain_q;
    unique case (j_q[1:0])
      2'd0:    sum_sel = csx_q;
      2'd1:    sum_sel = csy_q;
      2'd2:    sum_sel = tvx_q;
      default: sum_sel = tvy_q;
    endcase
    opa = 48'(acc_in_q[ax_q]);
    opb = 18'($signed({2'b00, tick_q}));
    unique case (state_q)
      S_IMUL: begin
        unique case (st_q)
          2'd0:    opa = 48'(acc_in_q[ax_q]);
          2'd1:    opa = 48'(adt_q);
          2'd2:    opa = 48'(vel_q[vidx]);
          default: opa = 48'(rate_in_q[ax_q]);
        endcase
      end
      S_FMUL: begin
        opa = 48'(sum_sel);
        opb = 18'($signed({2'b00, mpp_q}));
      end
      S_FVMUL: begin
        opa = clamp48(q_q);
        opb = 18'($signed({8'd0, fps_q}));
      end
      S_BMUL: begin
        opa = 48'(33'(tgt_q) - 33'(bold));
        opb = 18'($signed({2'b00, gsel}));
      end
      default: ;
    endcase
    prod_d = PROD_W'(opa) * PROD_W'(opb);
  end

  // track accumulation
  logic signed [32:0] hw_x, hw_y, cx, cy;
  always_comb begin
    hw_x = (33'(az_or_width_i) + 33'($signed({1'b0, az_or_width_i[31]}))) >>> 1;
    hw_y = (33'(gx_or_height_i) + 33'($signed({1'b0, gx_or_height_i[31]}))) >>> 1;
    cx   = 33'(ax_or_left_i) + hw_x;
    cy   = 33'(ay_or_top_i) + hw_y;
  end

  // divider step
  logic [CNT_W+1:0] dtrial;
  logic             dbit;
  always_comb begin
    dtrial = {rem_q, dvd_q[DVD_W-1]};
    dbit   = dtrial >= (CNT_W+2)'(cnt_q);
  end

  logic signed [56:0] qsign;
  assign qsign = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

  logic signed [PROD_W-1:0] bacc;
  assign bacc = ((PROD_W'(bold) <<< 16) + prod_q) >>> 16;

  logic signed [56:0] pmag;
  assign pmag = prod_q[56] ? -prod_q[56:0] : prod_q[56:0];

  logic in_acc, out_load;
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_q      <= TICK_PERIOD_RST;
      pgain_q     <= POS_GAIN_RST;
      vgain_q     <= VEL_GAIN_RST;
      mpp_q       <= MPP_RST;
      fps_q       <= FPS_RST;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        ang_q[i] <= '0;
      end
      csx_q       <= '0;
      csy_q       <= '0;
      tvx_q       <= '0;
      tvy_q       <= '0;
      cnt_q       <= '0;
      ax_q        <= '0;
      st_q        <= '0;
      j_q         <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index_i)
          REG_TICK_PERIOD: tick_q  <= cfg_data_i;
          REG_POS_GAIN:    pgain_q <= cfg_data_i;
          REG_VEL_GAIN:    vgain_q <= cfg_data_i;
          REG_MPP:         mpp_q   <= cfg_data_i;
          REG_FPS:         fps_q   <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall && !out_load) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            acc_in_q[0]  <= ax_or_left_i;
            acc_in_q[1]  <= ay_or_top_i;
            acc_in_q[2]  <= az_or_width_i;
            rate_in_q[0] <= gx_or_height_i;
            rate_in_q[1] <= gy_or_track_vx_i;
            rate_in_q[2] <= gz_or_track_vy_i;
            ax_q <= '0;
            st_q <= '0;
            j_q  <= '0;
            if (cmd_i == CMD_IMU) begin
              state_q <= S_IMUL;
            end else if (cmd_i == CMD_TRACK || cmd_i == CMD_TRACK_LAST) begin
              if (cnt_q < CNT_W'(MAX_TRACKS)) begin
                csx_q <= sat40(42'(csx_q) + 42'(cx));
                csy_q <= sat40(42'(csy_q) + 42'(cy));
                tvx_q <= sat40(42'(tvx_q) + 42'(gy_or_track_vx_i));
                tvy_q <= sat40(42'(tvy_q) + 42'(gz_or_track_vy_i));
                cnt_q <= cnt_q + 1'b1;
              end
              if (cmd_i == CMD_TRACK_LAST) state_q <= S_FMUL;
            end
          end
        end
        S_IMUL: begin
          prod_q  <= prod_d;
          state_q <= S_IACC;
        end
        S_IACC: begin
          unique case (st_q)
            2'd0: adt_q  <= prod_q[47:16];
            2'd1: half_q <= prod_q[48:17];
            2'd2: begin
              pos_q[pidx] <= sat32(PROD_W'(pos_q[pidx]) + (prod_q >>> 16)
                                   + PROD_W'(half_q));
              vel_q[vidx] <= sat32(PROD_W'(vel_q[vidx]) + PROD_W'(adt_q));
            end
            default: ang_q[ax_q] <= sat32(PROD_W'(ang_q[ax_q]) + (prod_q >>> 16));
          endcase
          st_q <= st_q + 1'b1;
          if (st_q == 2'd3) begin
            if (ax_q == 2'd2) begin
              ax_q    <= '0;
              state_q <= S_OUT;
            end else begin
              ax_q    <= ax_q + 1'b1;
              state_q <= S_IMUL;
            end
          end else begin
            state_q <= S_IMUL;
          end
        end
        S_FMUL: begin
          prod_q  <= prod_d;
          state_q <= S_FLOAD;
        end
        S_FLOAD: begin
          neg_q   <= prod_q[56];
          dvd_q   <= pmag[DVD_W-1:0];
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= S_FDIV;
        end
        S_FDIV: begin
          rem_q  <= dbit ? (CNT_W+1)'(dtrial - (CNT_W+2)'(cnt_q)) : dtrial[CNT_W:0];
          dvd_q  <= {dvd_q[DVD_W-2:0], dbit};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DIV_CNT_W'(DVD_W - 1)) state_q <= S_FSGN;
        end
        S_FSGN: begin
          if (j_q[1]) begin
            q_q     <= qsign;
            state_q <= S_FVMUL;
          end else begin
            tgt_q   <= sat32(PROD_W'(qsign));
            state_q <= S_BMUL;
          end
        end
        S_FVMUL: begin
          prod_q  <= prod_d;
          state_q <= S_FVTGT;
        end
        S_FVTGT: begin
          tgt_q   <= sat32(prod_q >>> 16);
          state_q <= S_BMUL;
        end
        S_BMUL: begin
          prod_q  <= prod_d;
          state_q <= S_BACC;
        end
        S_BACC: begin
          if (j_q == 3'd2 || j_q == 3'd3) vel_q[vidx] <= sat32(bacc);
          else pos_q[pidx] <= sat32(bacc);
          j_q <= j_q + 1'b1;
          if (j_q == 3'd4) begin
            csx_q   <= '0;
            csy_q   <= '0;
            tvx_q   <= '0;
            tvy_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_OUT;
          end else if (j_q == 3'd3) begin
            tgt_q   <= '0;
            state_q <= S_BMUL;
          end else begin
            state_q <= S_FMUL;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        out_q[i]     <= pos_q[i];
        out_q[3 + i] <= vel_q[i];
        out_q[6 + i] <= ang_q[i];
      end
    end
  end

  assign cfg_ready     = 1'b1;
  assign in_stall      = (state_q != S_IDLE);
  assign out_valid     = out_valid_q;
  assign pos_x_o       = out_q[0];
  assign pos_y_o       = out_q[1];
  assign pos_z_o       = out_q[2];
  assign vel_x_o       = out_q[3];
  assign vel_y_o       = out_q[4];
  assign vel_z_o       = out_q[5];
  assign roll_angle_o  = out_q[6];
  assign pitch_angle_o = out_q[7];
  assign yaw_angle_o   = out_q[8];

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IMU/visual pose estimator core. A bit-accurate
// pose predictor follows every accepted word and queues the expected pose
// after each IMU and last track word; each emitted pose is compared field by
// field. Directed IMU, track and register cases come first, then random frames,
// IMU steps and register rewrites under random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import imvpe_pkg::*;

  localparam longint LIMIT = 1500000;
  localparam int     SETTLE = 300;

  typedef logic signed [31:0] fields_t [6];
  typedef struct {
    logic signed [31:0] v [9];
  } pose_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           cmd_i = CMD_IMU;
  logic signed [31:0]   ax_or_left_i = '0, ay_or_top_i = '0, az_or_width_i = '0;
  logic signed [31:0]   gx_or_height_i = '0, gy_or_track_vx_i = '0, gz_or_track_vy_i = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [31:0]   pos_x_o, pos_y_o, pos_z_o, vel_x_o, vel_y_o, vel_z_o;
  logic signed [31:0]   roll_angle_o, pitch_angle_o, yaw_angle_o;

  imu_visual_pose_estimator_core dut (.*);

  // predictor state
  longint pose_q [9];
  longint csum_x, csum_y, vsum_x, vsum_y;
  int     n_tracks;
  longint dt_q, pgain, vgain, mpp, fps;

  pose_t  expected_poses [$];
  int     errors = 0;
  longint cycles = 0;
  bit     quiet = 1'b0;
  int     rx_wait = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch @%0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint clip40(input longint x);
    longint hi;
    hi = (64'sd1 <<< 39) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  function automatic longint mix(input longint old, input longint tgt, input longint g);
    return clip32(((65536 - g) * old + g * tgt) >>> 16);
  endfunction

  function automatic longint track_vel(input longint sum);
    longint q, lim;
    q = sum * mpp / n_tracks;
    lim = 64'sd1 <<< 47;
    if (q >= lim) q = lim - 1;
    if (q < -lim) q = -lim;
    return clip32((q * fps) >>> 16);
  endfunction

  function automatic void reset_pose();
    dt_q = TICK_PERIOD_RST; pgain = POS_GAIN_RST; vgain = VEL_GAIN_RST;
    mpp = MPP_RST; fps = FPS_RST;
    foreach (pose_q[i]) pose_q[i] = 0;
    csum_x = 0; csum_y = 0; vsum_x = 0; vsum_y = 0; n_tracks = 0;
  endfunction

  function automatic void advance_pose(input logic [1:0] c, input fields_t f);
    longint adt, half, vdt, px, py, vx, vy;
    pose_t  p;
    if (c == 2'd3) return;
    if (c == CMD_IMU) begin
      for (int i = 0; i < 3; i++) begin
        adt = (longint'(f[i]) * dt_q) >>> 16;
        half = (adt * dt_q) >>> 17;
        vdt = (pose_q[3+i] * dt_q) >>> 16;
        pose_q[i] = clip32(pose_q[i] + vdt + half);
        pose_q[3+i] = clip32(pose_q[3+i] + adt);
        pose_q[6+i] = clip32(pose_q[6+i] + ((longint'(f[3+i]) * dt_q) >>> 16));
      end
    end else begin
      if (n_tracks < MAX_TRACKS_DEF) begin
        csum_x = clip40(csum_x + longint'(f[0]) + longint'(f[2]) / 2);
        csum_y = clip40(csum_y + longint'(f[1]) + longint'(f[3]) / 2);
        vsum_x = clip40(vsum_x + longint'(f[4]));
        vsum_y = clip40(vsum_y + longint'(f[5]));
        n_tracks++;
      end
      if (c == CMD_TRACK) return;
      px = clip32(csum_x * mpp / n_tracks);
      py = clip32(csum_y * mpp / n_tracks);
      vx = track_vel(vsum_x);
      vy = track_vel(vsum_y);
      pose_q[0] = mix(pose_q[0], px, pgain);
      pose_q[1] = mix(pose_q[1], py, pgain);
      pose_q[2] = mix(pose_q[2], 0, pgain);
      pose_q[3] = mix(pose_q[3], vx, vgain);
      pose_q[4] = mix(pose_q[4], vy, vgain);
      csum_x = 0; csum_y = 0; vsum_x = 0; vsum_y = 0; n_tracks = 0;
    end
    foreach (p.v[i]) p.v[i] = pose_q[i][31:0];
    expected_poses.push_back(p);
  endfunction

  // result side
  always @(posedge clk_i) begin
    pose_t e;
    logic signed [31:0] got [9];
    if (out_valid && !out_stall) begin
      got = '{pos_x_o, pos_y_o, pos_z_o, vel_x_o, vel_y_o, vel_z_o,
              roll_angle_o, pitch_angle_o, yaw_angle_o};
      if (expected_poses.size() == 0) begin
        report("pose word with none expected");
      end else begin
        e = expected_poses.pop_front();
        foreach (got[i])
          if (got[i] !== e.v[i])
            report($sformatf("pose field %0d got %h want %h", i, got[i], e.v[i]));
      end
      rx_wait = quiet ? 0 : $urandom_range(0, 7);
    end
    if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(input logic [1:0] c, input fields_t f);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd_i <= c;
    ax_or_left_i <= f[0]; ay_or_top_i <= f[1]; az_or_width_i <= f[2];
    gx_or_height_i <= f[3]; gy_or_track_vx_i <= f[4]; gz_or_track_vy_i <= f[5];
    do @(posedge clk_i); while (in_stall);
    advance_pose(c, f);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TICK_PERIOD: dt_q = val;
      REG_POS_GAIN:    pgain = val;
      REG_VEL_GAIN:    vgain = val;
      REG_MPP:         mpp = val;
      REG_FPS:         fps = val[9:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] rnd_word(input int span);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send_imu(input int span);
    fields_t f;
    foreach (f[i]) f[i] = rnd_word(span);
    send_word(CMD_IMU, f);
  endtask

  task automatic send_frame(input int n);
    fields_t f;
    for (int k = 0; k < n; k++) begin
      f[0] = rnd_word(2000); f[1] = rnd_word(2000);
      f[2] = rnd_word(400);  f[3] = rnd_word(400);
      f[4] = rnd_word(1 << 20); f[5] = rnd_word(1 << 20);
      send_word(k == n - 1 ? CMD_TRACK_LAST : CMD_TRACK, f);
    end
  endtask

  task automatic test_imu_extremes();
    send_word(CMD_IMU, '{default: 32'sd0});
    send_word(CMD_IMU, '{default: 32'sh7fffffff});
    send_word(CMD_IMU, '{default: 32'sh7fffffff});
    send_word(CMD_IMU, '{default: 32'sh80000000});
    send_word(CMD_IMU, '{32'sh00010000, -32'sh00010000, 32'sh0, 32'sh1, -32'sh1, 32'sh5555});
    send_word(2'd3, '{default: 32'sh7fffffff});
  endtask

  task automatic test_track_cases();
    send_word(CMD_TRACK_LAST, '{32'sd100, 32'sd50, -32'sd3, -32'sd5, 32'sh8000, -32'sh8000});
    send_word(CMD_TRACK, '{default: 32'sh7fffffff});
    send_word(CMD_TRACK_LAST, '{default: 32'sh80000000});
    send_word(CMD_TRACK, '{32'sd7, 32'sd7, 32'sd3, 32'sd3, 32'sd1, 32'sd1});
    send_word(2'd3, '{default: 32'sd9});
    send_word(CMD_TRACK_LAST, '{32'sd0, 32'sd0, 32'sd1, -32'sd1, 32'sd0, 32'sd0});
    quiet = 1'b1;
    for (int k = 0; k < 69; k++)
      send_word(k == 68 ? CMD_TRACK_LAST : CMD_TRACK, '{default: 32'sh7fffffff});
    quiet = 1'b0;
  endtask

  task automatic test_registers();
    logic [15:0] lo [5] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    logic [15:0] hi [5] = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd1023};
    for (int s = 0; s < 4; s++) begin
      for (int r = 0; r < 5; r++)
        write_reg(r[CFG_IDX_W-1:0], s == 0 ? lo[r] : s == 1 ? hi[r] : 16'($urandom));
      if (s == 3) write_reg(REG_FPS, 16'd1000);
      send_imu(1 << 18);
      send_imu(1 << 18);
      send_frame(3);
      send_frame(1);
    end
    write_reg(REG_FPS, 16'd1);
    send_frame(2);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 1400) begin
      if (sent % 300 == 299) begin
        write_reg(REG_TICK_PERIOD, 16'($urandom_range(0, 8000)));
        write_reg(REG_POS_GAIN, 16'($urandom));
        write_reg(REG_VEL_GAIN, 16'($urandom));
        write_reg(REG_MPP, 16'($urandom_range(0, 4000)));
        write_reg(REG_FPS, 16'($urandom_range(1, 1000)));
      end
      quiet = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin send_imu(1 << 18); sent++; end
        4: begin send_imu(32'h7fffffff); sent++; end
        5: begin
          fields_t f;
          foreach (f[i]) f[i] = $urandom;
          send_word(2'd3, f);
        end
        6: begin drain(); send_frame(66); sent += 66; end
        default: begin
          int n;
          n = $urandom_range(1, 8);
          send_frame(n);
          sent += n;
        end
      endcase
    end
    quiet = 1'b0;
  endtask

  initial begin
    reset_pose();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_imu_extremes();
    test_track_cases();
    drain();
    test_registers();
    test_random();
    drain();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
